// File: rtl/core/rcfa_pkg.sv
// ----------------------------------------------------------------------------
// Reference-counted frame allocator package
// Shared constants, beat types, command and status codes, bitmap helpers.
// ----------------------------------------------------------------------------
package rcfa_pkg;

    localparam int FRAME_COUNT = 1024;
    localparam int COUNT_WIDTH = 16;
    localparam int RESERVED    = 2;

    localparam int IDX_W    = 10;
    localparam int REF_W    = 16;
    localparam int STATUS_W = 3;

    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = (FRAME_COUNT + WORD_W - 1) / WORD_W;
    localparam int WSEL_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ADDREF  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NO_FREE   = 3'd1,
        STS_RESERVED  = 3'd2,
        STS_NOT_ALLOC = 3'd3,
        STS_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] frame_index;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0] result_frame;
        logic [REF_W-1:0] ref_count;
        t_status          status;
    } t_out_beat;

    typedef struct packed {
        logic              rd_en;
        logic              rd_search;
        logic [WSEL_W-1:0] rd_word;
        logic              wr_en;
        logic [WSEL_W-1:0] wr_word;
        logic [WORD_W-1:0] wr_data;
    } t_map_req;

    typedef struct packed {
        logic              any_free;
        logic [WSEL_W-1:0] word;
        logic [WORD_W-1:0] bits;
    } t_map_rsp;

    function automatic logic [BIT_W-1:0] first_bit(logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WSEL_W-1:0] first_word(logic [WORDS-1:0] v);
        logic [WSEL_W-1:0] r;
        r = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = WSEL_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] init_bits(logic [WSEL_W-1:0] w);
        logic [WORD_W-1:0] r;
        int                f;
        for (int b = 0; b < WORD_W; b++) begin
            f    = int'(w) * WORD_W + b;
            r[b] = (f >= RESERVED) && (f < FRAME_COUNT);
        end
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_of(logic [WSEL_W-1:0] w,
                                                    logic [BIT_W-1:0] b);
        return FRAME_W'({w, b});
    endfunction

    function automatic logic [WSEL_W-1:0] word_of(logic [FRAME_W-1:0] f);
        return WSEL_W'(f >> BIT_W);
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(logic [FRAME_W-1:0] f);
        return BIT_W'(f);
    endfunction

    function automatic logic [REF_W-1:0] to_ref(logic [COUNT_WIDTH-1:0] c);
        return REF_W'(c);
    endfunction

endpackage

// File: rtl/core/refcounted_frame_allocator.sv
// ----------------------------------------------------------------------------
// Reference-counted frame allocator
// First-fit frame allocation with a per-frame reference count memory.
// ----------------------------------------------------------------------------
// Operation: an accepted input beat reads the count and bitmap memories into
//   registers in S_IDLE; S_EXEC then modifies, writes back and loads the result
//   slot, and is held while the result slot is full. No new beat is accepted
//   until S_EXEC ends. Reset: an init sweep over every frame index rewrites the
//   count and bitmap memories; o_in_stall stays high until it ends.
module refcounted_frame_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rcfa_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rcfa_pkg::t_out_beat o_out_beat
);

    rcfa_pkg::t_state    r_state, n_state;
    logic [rcfa_pkg::FRAME_W-1:0]     r_init;
    rcfa_pkg::t_cmd                   r_cmd;
    logic [rcfa_pkg::IDX_W-1:0]       r_idx;
    logic [rcfa_pkg::FRAME_W-1:0]     r_frame;
    logic                             r_in_range;
    logic [rcfa_pkg::COUNT_WIDTH-1:0] r_count_mem [rcfa_pkg::FRAME_COUNT];
    logic [rcfa_pkg::COUNT_WIDTH-1:0] r_cnt_rd;
    logic                             r_out_valid;
    rcfa_pkg::t_out_beat              r_out, n_out;

    rcfa_pkg::t_map_req               map_req;
    rcfa_pkg::t_map_rsp               map_rsp;

    logic                             in_acc;
    logic                             out_free;
    logic                             out_load;
    logic [rcfa_pkg::FRAME_W-1:0]     in_frame;
    logic                             in_range;
    logic                             cnt_re;
    logic                             cnt_we;
    logic [rcfa_pkg::FRAME_W-1:0]     cnt_waddr;
    logic [rcfa_pkg::COUNT_WIDTH-1:0] cnt_wdata;
    logic [rcfa_pkg::BIT_W-1:0]       fbit;
    logic [rcfa_pkg::FRAME_W-1:0]     alloc_frame;
    logic [rcfa_pkg::COUNT_WIDTH-1:0] cnt_dec;

    rcfa_free_map u_free_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    assign o_in_stall  = (r_state != rcfa_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_frame    = rcfa_pkg::FRAME_W'(i_in_beat.frame_index);
    assign in_range    = int'(i_in_beat.frame_index) < rcfa_pkg::FRAME_COUNT;
    assign fbit        = rcfa_pkg::first_bit(map_rsp.bits);
    assign alloc_frame = rcfa_pkg::frame_of(map_rsp.word, fbit);
    assign cnt_dec     = r_cnt_rd - 1'b1;

    always_comb begin
        n_state   = r_state;
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = r_frame;
        cnt_wdata = '0;
        out_load  = 1'b0;
        map_req   = '0;
        n_out     = '0;
        case (r_state)
            rcfa_pkg::S_INIT: begin
                cnt_we          = 1'b1;
                cnt_waddr       = r_init;
                cnt_wdata       = rcfa_pkg::COUNT_WIDTH'(int'(r_init) < rcfa_pkg::RESERVED);
                map_req.wr_en   = int'(r_init) < rcfa_pkg::WORDS;
                map_req.wr_word = rcfa_pkg::WSEL_W'(r_init);
                map_req.wr_data = rcfa_pkg::init_bits(rcfa_pkg::WSEL_W'(r_init));
                if (r_init == rcfa_pkg::FRAME_W'(rcfa_pkg::FRAME_COUNT - 1)) begin
                    n_state = rcfa_pkg::S_IDLE;
                end
            end
            rcfa_pkg::S_IDLE: begin
                if (in_acc) begin
                    cnt_re            = 1'b1;
                    map_req.rd_en     = 1'b1;
                    map_req.rd_search = (i_in_beat.cmd == rcfa_pkg::CMD_ALLOC);
                    map_req.rd_word   = rcfa_pkg::word_of(in_frame);
                    n_state           = rcfa_pkg::S_EXEC;
                end
            end
            rcfa_pkg::S_EXEC: begin
                n_out.result_frame = r_idx;
                n_out.ref_count    = rcfa_pkg::to_ref(r_cnt_rd);
                n_out.status       = rcfa_pkg::STS_OK;
                map_req.wr_word    = map_rsp.word;
                if (r_cmd == rcfa_pkg::CMD_ALLOC) begin
                    if (!map_rsp.any_free) begin
                        n_out.result_frame = '0;
                        n_out.ref_count    = '0;
                        n_out.status       = rcfa_pkg::STS_NO_FREE;
                    end else begin
                        n_out.result_frame = rcfa_pkg::IDX_W'(alloc_frame);
                        n_out.ref_count    = rcfa_pkg::REF_W'(1);
                        cnt_we             = 1'b1;
                        cnt_waddr          = alloc_frame;
                        cnt_wdata          = rcfa_pkg::COUNT_WIDTH'(1);
                        map_req.wr_en      = 1'b1;
                        map_req.wr_data    = map_rsp.bits
                                           & ~(rcfa_pkg::WORD_W'(1) << fbit);
                    end
                end else if (!r_in_range) begin
                    n_out.ref_count = '0;
                    n_out.status    = rcfa_pkg::STS_NOT_ALLOC;
                end else if (r_cmd == rcfa_pkg::CMD_QUERY) begin
                    n_out.status = rcfa_pkg::STS_OK;
                end else if (int'(r_idx) < rcfa_pkg::RESERVED) begin
                    n_out.status = rcfa_pkg::STS_RESERVED;
                end else if (r_cnt_rd == '0) begin
                    n_out.ref_count = '0;
                    n_out.status    = rcfa_pkg::STS_NOT_ALLOC;
                end else if (r_cmd == rcfa_pkg::CMD_ADDREF) begin
                    if (r_cnt_rd == '1) begin
                        n_out.status = rcfa_pkg::STS_OVERFLOW;
                    end else begin
                        cnt_we          = 1'b1;
                        cnt_wdata       = r_cnt_rd + 1'b1;
                        n_out.ref_count = rcfa_pkg::to_ref(cnt_wdata);
                    end
                end else begin
                    cnt_we          = 1'b1;
                    cnt_wdata       = cnt_dec;
                    n_out.ref_count = rcfa_pkg::to_ref(cnt_dec);
                    map_req.wr_en   = (cnt_dec == '0);
                    map_req.wr_data = map_rsp.bits
                                    | (rcfa_pkg::WORD_W'(1) << rcfa_pkg::bit_of(r_frame));
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = rcfa_pkg::S_IDLE;
                end else begin
                    cnt_we        = 1'b0;
                    map_req.wr_en = 1'b0;
                end
            end
            default: begin
                n_state = rcfa_pkg::S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcfa_pkg::S_INIT;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rcfa_pkg::S_INIT) begin
                r_init <= r_init + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_in_beat.cmd;
            r_idx      <= i_in_beat.frame_index;
            r_frame    <= in_frame;
            r_in_range <= in_range;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= r_count_mem[in_frame];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_alloc_word_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcfa_pkg::S_EXEC && r_cmd == rcfa_pkg::CMD_ALLOC && map_rsp.any_free)
        |-> (map_rsp.bits != '0))
        else $error("allocation picked a bitmap word with no free frame");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == rcfa_pkg::S_EXEC))
        else $error("result beat appeared without an executed command");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (r_state != rcfa_pkg::S_IDLE))
        else $error("count memory written in the accept cycle");

endmodule

// File: rtl/core/rcfa_free_map.sv
// ----------------------------------------------------------------------------
// Free-frame bitmap
// One bit per frame (set = free) in a word memory, plus a per-word summary
// that picks the lowest word holding a free frame.
// ----------------------------------------------------------------------------
module rcfa_free_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcfa_pkg::t_map_req i_req,
    output rcfa_pkg::t_map_rsp o_rsp
);

    logic [rcfa_pkg::WORD_W-1:0] r_map_mem [rcfa_pkg::WORDS];
    logic [rcfa_pkg::WORDS-1:0]  r_summary;
    logic [rcfa_pkg::WORD_W-1:0] r_bits;
    logic [rcfa_pkg::WSEL_W-1:0] r_word;
    logic                        r_any;
    logic [rcfa_pkg::WSEL_W-1:0] rd_addr;

    assign rd_addr = i_req.rd_search ? rcfa_pkg::first_word(r_summary) : i_req.rd_word;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_map_mem[i_req.wr_word] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_bits <= r_map_mem[rd_addr];
            r_word <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= '0;
            r_any     <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_summary[i_req.wr_word] <= |i_req.wr_data;
            end
            if (i_req.rd_en) begin
                r_any <= i_req.rd_search ? |r_summary : 1'b1;
            end
        end
    end

    assign o_rsp.any_free = r_any;
    assign o_rsp.word     = r_word;
    assign o_rsp.bits     = r_bits;

endmodule
